// File: design/gnss_frame_sync_crc24q_checker_top_defines.svh
// ----------------------------------------------------------------------------
// GNSS frame sync checker assertion macros
// Shared property wrappers for the checker bound to the top level.
// ----------------------------------------------------------------------------
`ifndef GNSS_FRAME_SYNC_CRC24Q_CHECKER_TOP_DEFINES_SVH
`define GNSS_FRAME_SYNC_CRC24Q_CHECKER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define GFSC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define GFSC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// same-cycle implication, checked through reset as well
`define GFSC_ASSERT_ALL(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: design/gfsc_pkg.sv
// ----------------------------------------------------------------------------
// GNSS frame sync package
// Types, codes and CRC-24Q helpers shared by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gfsc_pkg;

   localparam int unsigned LENGTH_BITS_DEFAULT = 16;
   localparam int unsigned QUEUE_DEPTH         = 2;

   localparam logic [31:0] SHORT_SYNC    = 32'h4748_5343;
   localparam logic [63:0] LONG_SYNC     = 64'h4154_4144_5845_4824;
   localparam logic [23:0] CRC_POLY      = 24'h864C_FB;
   localparam logic [15:0] POSITION_TYPE = 16'hF090;
   localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEAD,
      PH_BODY,
      PH_CHECK
   } phase_type;

   typedef enum logic [2:0] {
      STATUS_DISPATCHED = 3'd0,
      STATUS_CRC_BAD    = 3'd1,
      STATUS_TOO_SHORT  = 3'd2,
      STATUS_IONO       = 3'd3,
      STATUS_UNKNOWN    = 3'd4,
      STATUS_OVER_LIMIT = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      CLASS_BD2         = 4'd0,
      CLASS_BD3         = 4'd1,
      CLASS_CNAV2       = 4'd2,
      CLASS_CNAV3       = 4'd3,
      CLASS_BDXW        = 4'd4,
      CLASS_GPS         = 4'd5,
      CLASS_GLONASS     = 4'd6,
      CLASS_GALILEO     = 4'd7,
      CLASS_PSEUDORANGE = 4'd8,
      CLASS_POSITION    = 4'd9,
      CLASS_NONE        = 4'd10
   } class_type;

   // frame end record handed from the parser to the reporting stage
   typedef struct packed {
      logic        long_sync;
      logic [15:0] frame_type;
      logic [15:0] payload_length;
      logic [23:0] computed_crc;
      logic        crc_good;
      logic        over_limit;
   } event_type;

   // one byte of CRC-24Q, MSB first
   function automatic logic [23:0] crc24q_step(logic [23:0] crc, logic [7:0] data);
      logic [23:0] c;
      c = crc ^ {data, 16'h0000};
      for (int k = 0; k < 8; k++) begin
         if (c[23]) begin
            c = {c[22:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[22:0], 1'b0};
         end
      end
      return c;
   endfunction

   // CRC over the bytes of a sync word, lowest byte first, from byte 'first' on
   function automatic logic [23:0] sync_crc(logic [63:0] word, int unsigned first);
      logic [23:0] c;
      c = 24'h000000;
      for (int k = 0; k < 8; k++) begin
         if (k >= first) begin
            c = crc24q_step(c, word[8*k +: 8]);
         end
      end
      return c;
   endfunction

   localparam logic [23:0] SHORT_SYNC_CRC = sync_crc({SHORT_SYNC, 32'h0000_0000}, 4);
   localparam logic [23:0] LONG_SYNC_CRC  = sync_crc(LONG_SYNC, 0);

endpackage

`default_nettype wire

// File: design/gfsc_if.sv
// ----------------------------------------------------------------------------
// GNSS frame sync channel interfaces
// Valid/ready channels for bytes in, frame reports out and the limit register.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface gfsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        long_sync;
   logic [15:0] frame_type;
   logic [15:0] payload_length;
   logic [23:0] computed_crc;
   logic        crc_good;
   logic [2:0]  frame_status;
   logic [3:0]  decoder_class;

   modport source (output valid, output long_sync, output frame_type,
                   output payload_length, output computed_crc, output crc_good,
                   output frame_status, output decoder_class, input ready);
   modport sink   (input valid, input long_sync, input frame_type,
                   input payload_length, input computed_crc, input crc_good,
                   input frame_status, input decoder_class, output ready);
endinterface

interface gfsc_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] max_payload_length;

   modport source (output valid, output max_payload_length, input ready);
   modport sink   (input valid, input max_payload_length, output ready);
endinterface

`default_nettype wire

// File: design/gnss_frame_sync_crc24q_checker_top.sv
// A frame's record is posted as its last CRC byte is taken (its last length
// byte if over limit) and reaches rsp_chan via the queue and report register.
// Throughput: one byte per cycle; req_chan.ready drops only while the
// two-entry record queue is full behind a stalled report register.
// Synchronous reset clears the parser to hunting, empties the queue and the
// report register, and sets the payload limit to 65535.
// ----------------------------------------------------------------------------
// GNSS frame sync CRC-24Q checker
// Byte-serial deframer: sync hunt, header capture, CRC check, frame report.
// ----------------------------------------------------------------------------
`default_nettype none

module gnss_frame_sync_crc24q_checker_top
   import gfsc_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   gfsc_req_if.sink   req_chan,
   gfsc_rsp_if.source rsp_chan,
   gfsc_csr_if.sink   csr_chan
);

   logic [15:0] max_len_ff;
   logic        queue_full;
   logic        push;
   event_type   push_event;
   logic        pop;
   logic        head_valid;
   event_type   head_event;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_chan.valid) begin
         max_len_ff <= csr_chan.max_payload_length;
      end
   end

   gfsc_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .max_len    (max_len_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_event (push_event)
   );

   gfsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_event (head_event)
   );

   gfsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_event (head_event),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

// File: design/gfsc_front.sv
// ----------------------------------------------------------------------------
// GNSS frame sync parser
// Hunts for sync, captures header, runs CRC-24Q and posts a frame end record.
// ----------------------------------------------------------------------------
`default_nettype none

module gfsc_front
   import gfsc_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   gfsc_req_if.sink         req_chan,
   input  wire logic [15:0] max_len,
   input  wire logic        queue_full,
   output      logic        push,
   output      event_type   push_event
);

   localparam logic [16:0] LEN_LIMIT = 17'((64'd1 << LENGTH_BITS) - 64'd1);

   phase_type               phase_ff, phase_in;
   logic [63:0]             window_ff, window_in;
   logic [1:0]              idx_ff, idx_in;
   logic [LENGTH_BITS-1:0]  count_ff, count_in;
   logic [15:0]             type_ff, type_in;
   logic [15:0]             len_ff, len_in;
   logic [23:0]             crc_ff, crc_in;
   logic [23:0]             rcv_ff, rcv_in;
   logic                    long_ff, long_in;

   logic                    accept;
   logic [7:0]              data;
   logic [63:0]             window_next;
   logic                    short_hit, long_hit;
   logic [15:0]             len_next;
   logic                    over_limit;
   logic [LENGTH_BITS-1:0]  count_next;
   logic                    body_done;
   logic [23:0]             rcv_next;
   logic [23:0]             crc_next;

   assign req_chan.ready = ~queue_full;
   assign accept         = req_chan.valid & ~queue_full;
   assign data           = req_chan.in_byte;

   assign window_next = {data, window_ff[63:8]};
   assign short_hit   = (window_next[63:32] == SHORT_SYNC);
   assign long_hit    = (window_next == LONG_SYNC);
   assign len_next    = {data, len_ff[7:0]};
   assign over_limit  = ({1'b0, len_next} > {1'b0, max_len}) || ({1'b0, len_next} > LEN_LIMIT);
   assign count_next  = count_ff + 1'b1;
   assign body_done   = (count_next >= len_ff[LENGTH_BITS-1:0]);
   assign rcv_next    = {rcv_ff[15:0], data};
   assign crc_next    = crc24q_step(crc_ff, data);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (short_hit || long_hit) begin
                  phase_in = PH_HEAD;
               end
            end
            PH_HEAD: begin
               if (idx_ff == 2'd3) begin
                  if (over_limit) begin
                     phase_in = PH_HUNT;
                  end else if (len_next == 16'h0000) begin
                     phase_in = PH_CHECK;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               if (body_done) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               if (idx_ff == 2'd2) begin
                  phase_in = PH_HUNT;
               end
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   // datapath and frame end record
   always_comb begin
      window_in  = window_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      type_in    = type_ff;
      len_in     = len_ff;
      crc_in     = crc_ff;
      rcv_in     = rcv_ff;
      long_in    = long_ff;
      push       = 1'b0;
      push_event = '{long_sync:      long_ff,
                     frame_type:     type_ff,
                     payload_length: len_ff,
                     computed_crc:   crc_ff,
                     crc_good:       (rcv_next == crc_ff),
                     over_limit:     1'b0};
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               window_in = window_next;
               if (short_hit || long_hit) begin
                  // short sync wins when both match
                  long_in   = ~short_hit;
                  crc_in    = short_hit ? SHORT_SYNC_CRC : LONG_SYNC_CRC;
                  window_in = '0;
                  idx_in    = 2'd0;
                  count_in  = '0;
               end
            end
            PH_HEAD: begin
               crc_in = crc_next;
               unique case (idx_ff)
                  2'd0:    type_in[7:0]  = data;
                  2'd1:    type_in[15:8] = data;
                  2'd2:    len_in[7:0]   = data;
                  default: len_in[15:8]  = data;
               endcase
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  idx_in   = 2'd0;
                  count_in = '0;
                  if (over_limit) begin
                     push                      = 1'b1;
                     push_event.payload_length = len_next;
                     push_event.over_limit     = 1'b1;
                     push_event.crc_good       = 1'b0;
                  end
               end
            end
            PH_BODY: begin
               crc_in   = crc_next;
               count_in = body_done ? '0 : count_next;
            end
            PH_CHECK: begin
               rcv_in = rcv_next;
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd2) begin
                  idx_in = 2'd0;
                  push   = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         window_ff <= '0;
         idx_ff    <= '0;
         count_ff  <= '0;
         long_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         window_ff <= window_in;
         idx_ff    <= idx_in;
         count_ff  <= count_in;
         long_ff   <= long_in;
      end
   end

   // header, CRC and received CRC are rewritten before any use after a sync
   always_ff @(posedge clock) begin
      type_ff <= type_in;
      len_ff  <= len_in;
      crc_ff  <= crc_in;
      rcv_ff  <= rcv_in;
   end

endmodule

`default_nettype wire

// File: design/gfsc_queue.sv
// ----------------------------------------------------------------------------
// GNSS frame sync record queue
// Short FIFO of frame end records between parser and reporting stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gfsc_queue
   import gfsc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire event_type push_event,
   output      logic      full,
   input  wire logic      pop,
   output      logic      head_valid,
   output      event_type head_event
);

   localparam int unsigned PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [COUNT_BITS-1:0] DEPTH_COUNT = COUNT_BITS'(QUEUE_DEPTH);
   localparam logic [PTR_BITS-1:0]   LAST_PTR    = PTR_BITS'(QUEUE_DEPTH - 1);

   event_type               entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    do_pop;

   assign full       = (count_ff == DEPTH_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_event = entries_ff[rd_ptr_ff];
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_event;
      end
   end

endmodule

`default_nettype wire

// File: design/gfsc_back.sv
// ----------------------------------------------------------------------------
// GNSS frame sync reporting stage
// Classifies each frame end record and holds the report in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gfsc_back
   import gfsc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      head_valid,
   input  wire event_type head_event,
   output      logic      pop,
   gfsc_rsp_if.source     rsp_chan
);

   logic        valid_ff, valid_in;
   logic        long_ff;
   logic [15:0] type_ff;
   logic [15:0] len_ff;
   logic [23:0] crc_ff;
   logic        good_ff;
   status_type  status_ff, status_in;
   class_type   class_ff, class_in;

   class_type   pick;
   logic [6:0]  need;
   logic        known;
   logic        iono;

   assign pop      = head_valid & (~valid_ff | rsp_chan.ready);
   assign valid_in = pop | (valid_ff & ~rsp_chan.ready);

   // decoder pick from the type, before the length rule
   always_comb begin
      pick  = CLASS_NONE;
      need  = 7'd1;
      known = 1'b1;
      iono  = 1'b0;
      if (head_event.long_sync) begin
         if (head_event.frame_type == POSITION_TYPE) begin
            pick = CLASS_POSITION;
            need = 7'd70;
         end else begin
            known = 1'b0;
         end
      end else begin
         unique case (head_event.frame_type)
            16'd1: begin
               pick = CLASS_BD2;
               need = 7'd67;
            end
            16'd2: begin
               pick = CLASS_BD3;
               need = 7'd76;
            end
            16'd3:  pick = CLASS_CNAV2;
            16'd4:  pick = CLASS_CNAV3;
            16'd41: pick = CLASS_BDXW;
            16'd11: begin
               pick = CLASS_GPS;
               need = 7'd64;
            end
            16'd21: pick = CLASS_GLONASS;
            16'd31, 16'd32: begin
               pick = CLASS_GALILEO;
               need = 7'd66;
            end
            16'd61, 16'd62: pick = CLASS_PSEUDORANGE;
            16'd205, 16'd206, 16'd214: iono = 1'b1;
            default: known = 1'b0;
         endcase
      end
   end

   always_comb begin
      class_in = CLASS_NONE;
      priority if (head_event.over_limit) begin
         status_in = STATUS_OVER_LIMIT;
      end else if (!head_event.crc_good) begin
         status_in = STATUS_CRC_BAD;
      end else if (iono) begin
         status_in = STATUS_IONO;
      end else if (!known) begin
         status_in = STATUS_UNKNOWN;
      end else if (head_event.payload_length < {9'd0, need}) begin
         status_in = STATUS_TOO_SHORT;
      end else begin
         status_in = STATUS_DISPATCHED;
         class_in  = pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         long_ff   <= head_event.long_sync;
         type_ff   <= head_event.frame_type;
         len_ff    <= head_event.payload_length;
         crc_ff    <= head_event.over_limit ? 24'h000000 : head_event.computed_crc;
         good_ff   <= head_event.crc_good & ~head_event.over_limit;
         status_ff <= status_in;
         class_ff  <= class_in;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.long_sync      = long_ff;
   assign rsp_chan.frame_type     = type_ff;
   assign rsp_chan.payload_length = len_ff;
   assign rsp_chan.computed_crc   = crc_ff;
   assign rsp_chan.crc_good       = good_ff;
   assign rsp_chan.frame_status   = status_ff;
   assign rsp_chan.decoder_class  = class_ff;

endmodule

`default_nettype wire

// File: design/gfsc_checker.sv
// ----------------------------------------------------------------------------
// GNSS frame sync port checker
// Watches the report channel of the top level for consistent frame reports.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gnss_frame_sync_crc24q_checker_top_defines.svh"

module gfsc_checker
   import gfsc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        long_sync,
   input wire logic [15:0] frame_type,
   input wire logic [15:0] payload_length,
   input wire logic [23:0] computed_crc,
   input wire logic        crc_good,
   input wire logic [2:0]  frame_status,
   input wire logic [3:0]  decoder_class
);

   // a stalled report holds
   `GFSC_ASSERT_NXT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready), (rsp_valid && $stable({long_sync, frame_type, payload_length, computed_crc, crc_good, frame_status, decoder_class})), "report changed while stalled")

   // a dropped over-limit frame carries no CRC and no decoder
   `GFSC_ASSERT_IMP(a_over_fields, clock, reset, (rsp_valid && frame_status == STATUS_OVER_LIMIT), (computed_crc == 24'h000000 && !crc_good && decoder_class == CLASS_NONE), "over-limit report with CRC or decoder")

   // CRC verdict and status agree
   `GFSC_ASSERT_IMP(a_crc_status, clock, reset, (rsp_valid && frame_status != STATUS_OVER_LIMIT), (crc_good == (frame_status != STATUS_CRC_BAD)), "CRC verdict disagrees with status")

   // a decoder is picked only for a dispatched frame
   `GFSC_ASSERT_IMP(a_class_status, clock, reset, (rsp_valid && decoder_class != CLASS_NONE), (frame_status == STATUS_DISPATCHED), "decoder picked for a frame not dispatched")

   // no report right after reset
   `GFSC_ASSERT_ALL(a_reset_empty, clock, ($past(reset)), (!rsp_valid), "report valid after reset")

endmodule

bind gnss_frame_sync_crc24q_checker_top gfsc_checker u_gfsc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .long_sync      (rsp_chan.long_sync),
   .frame_type     (rsp_chan.frame_type),
   .payload_length (rsp_chan.payload_length),
   .computed_crc   (rsp_chan.computed_crc),
   .crc_good       (rsp_chan.crc_good),
   .frame_status   (rsp_chan.frame_status),
   .decoder_class  (rsp_chan.decoder_class)
);

`default_nettype wire
